// ----- src/hbs_pkg.sv -----
// Shared types and constants of the heightmap bilinear sampler.
package hbs_pkg;

    localparam int GRID_SIZE_DEF = 256;

    localparam int CFG_DATA_W = 12;
    localparam int SIZE_W     = 9;
    localparam int COORD_W    = 17;
    localparam int HEIGHT_W   = 16;
    localparam int MAXH_W     = 12;
    localparam int WORLD_W    = 28;
    localparam int WEIGHT_W   = 17;
    localparam int BLEND_W    = 32;
    localparam int SCALED_W   = 44;

    localparam logic [SIZE_W-1:0] TERRAIN_SIZE_RST = 9'd256;
    localparam logic [MAXH_W-1:0] MAX_HEIGHT_RST   = 12'd256;
    localparam logic [MAXH_W-1:0] MAX_HEIGHT_CAP   = 12'd2048;

    // Round half up before dividing by the full-scale value 65535.
    localparam logic [SCALED_W-1:0] ROUND_BIAS = 44'd32767;
    localparam logic [16:0]         FULL_SCALE = 17'd65535;

    localparam logic CFG_TERRAIN_SIZE = 1'b0;
    localparam logic CFG_MAX_HEIGHT   = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       clear_en;
        logic       write_en;
        logic       rd_en;
        logic [1:0] vtx;
        logic       mul_en;
        logic       acc_en;
        logic       scale_en;
        logic       reduce_en;
        logic       load_result;
    } hbs_cmd_t;

    typedef struct packed {
        logic in_err;
        logic clear_last;
    } hbs_stat_t;

endpackage

// ----- src/hbs_ram.sv -----
// Generic single-port RAM with registered read.
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/hbs_ctrl.sv -----
// Controller state machine of the heightmap bilinear sampler.
module hbs_ctrl import hbs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      kind,
    input  hbs_stat_t stat,
    output hbs_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b000_0001,
        ST_IDLE   = 7'b000_0010,
        ST_WRITE  = 7'b000_0100,
        ST_FETCH  = 7'b000_1000,
        ST_SCALE  = 7'b001_0000,
        ST_REDUCE = 7'b010_0000,
        ST_FINISH = 7'b100_0000
    } hbs_state_t;

    // Four vertex reads, then FETCH waits for the last multiply and accumulate to drain.
    localparam logic [2:0] FETCH_READS = 3'd4;
    localparam logic [2:0] FETCH_LAST  = 3'd5;

    hbs_state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       mul_en_reg;
    logic       acc_en_reg;
    logic       rd_en;

    assign rd_en = (state_reg == ST_FETCH) && (cnt_reg < FETCH_READS);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next = 3'd0;
                    if (kind == KIND_WRITE)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (stat.in_err)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_WRITE:  state_next = ST_FINISH;
            ST_FETCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == FETCH_LAST)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= 3'd0;
            mul_en_reg <= 1'b0;
            acc_en_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mul_en_reg <= rd_en;
            acc_en_reg <= mul_en_reg;
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.capture     = (state_reg == ST_IDLE) && start;
        cmd.clear_en    = (state_reg == ST_CLEAR);
        cmd.write_en    = (state_reg == ST_WRITE);
        cmd.rd_en       = rd_en;
        cmd.vtx         = cnt_reg[1:0];
        cmd.mul_en      = mul_en_reg;
        cmd.acc_en      = acc_en_reg;
        cmd.scale_en    = (state_reg == ST_SCALE);
        cmd.reduce_en   = (state_reg == ST_REDUCE);
        cmd.load_result = (state_reg == ST_FINISH);
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- src/hbs_datapath.sv -----
// Datapath of the heightmap bilinear sampler: config, grid RAM, blend and scale.
module hbs_datapath import hbs_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  kind,
    input  logic [COORD_W-1:0]    sample_x,
    input  logic [COORD_W-1:0]    sample_z,
    input  logic [SIZE_W-1:0]     vertex_x,
    input  logic [SIZE_W-1:0]     vertex_z,
    input  logic [HEIGHT_W-1:0]   vertex_value,
    input  hbs_cmd_t              cmd,
    output hbs_stat_t             stat,
    output logic                  done,
    output logic [WORLD_W-1:0]    world_height,
    output logic                  status
);

    localparam int STRIDE   = GRID_SIZE + 1;
    localparam int DEPTH    = STRIDE * STRIDE;
    localparam int AW       = $clog2(DEPTH);
    localparam int SIZE_MAX = (GRID_SIZE < 511) ? GRID_SIZE : 511;
    localparam logic [SIZE_W-1:0] SIZE_CAP  = SIZE_W'(SIZE_MAX);
    localparam logic [AW-1:0]     ROW_STEP  = AW'(STRIDE);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(DEPTH - 1);

    // Configuration registers
    logic [SIZE_W-1:0] terrain_size_reg;
    logic [MAXH_W-1:0] max_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terrain_size_reg <= TERRAIN_SIZE_RST;
            max_height_reg   <= MAX_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TERRAIN_SIZE: terrain_size_reg <= cfg_data[SIZE_W-1:0];
                CFG_MAX_HEIGHT:   max_height_reg   <= cfg_data[MAXH_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [SIZE_W-1:0] size_eff;
    logic [MAXH_W-1:0] maxh_eff;

    always_comb
    begin
        size_eff = (terrain_size_reg > SIZE_CAP) ? SIZE_CAP : terrain_size_reg;
        if (size_eff == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        maxh_eff = (max_height_reg > MAX_HEIGHT_CAP) ? MAX_HEIGHT_CAP : max_height_reg;
    end

    // Range check and cell clamp on the incoming word
    logic [COORD_W-1:0] size_fixed;
    logic               in_err;
    logic [SIZE_W-1:0]  cell_x, cell_z;
    logic [SIZE_W-1:0]  frac_x, frac_z;

    always_comb
    begin
        size_fixed = {size_eff, 8'd0};
        if (kind == KIND_SAMPLE)
        begin
            in_err = (sample_x > size_fixed) || (sample_z > size_fixed);
        end
        else
        begin
            in_err = (vertex_x > size_eff) || (vertex_z > size_eff);
        end
        cell_x = sample_x[COORD_W-1:8];
        frac_x = {1'b0, sample_x[7:0]};
        cell_z = sample_z[COORD_W-1:8];
        frac_z = {1'b0, sample_z[7:0]};
        // On the far edge use the last cell with a full weight on its upper vertex.
        if (cell_x >= size_eff)
        begin
            cell_x = size_eff - SIZE_W'(1);
            frac_x = 9'd256;
        end
        if (cell_z >= size_eff)
        begin
            cell_z = size_eff - SIZE_W'(1);
            frac_z = 9'd256;
        end
    end

    logic                kind_reg, err_reg;
    logic [SIZE_W-1:0]   cell_x_reg, cell_z_reg, frac_x_reg, frac_z_reg;
    logic [SIZE_W-1:0]   vx_reg, vz_reg;
    logic [HEIGHT_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            err_reg    <= in_err;
            cell_x_reg <= cell_x;
            cell_z_reg <= cell_z;
            frac_x_reg <= frac_x;
            frac_z_reg <= frac_z;
            vx_reg     <= vertex_x;
            vz_reg     <= vertex_z;
            value_reg  <= vertex_value;
        end
    end

    // Clear sweep address
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_en && (clr_addr_reg != LAST_ADDR))
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    assign stat.in_err     = in_err;
    assign stat.clear_last = (clr_addr_reg == LAST_ADDR);

    // Grid address: one constant multiply shared by writes and vertex reads
    logic [SIZE_W-1:0]   sel_x, sel_z;
    logic [AW-1:0]       vtx_addr, ram_addr;
    logic                ram_en, ram_we;
    logic [HEIGHT_W-1:0] ram_wdata, ram_rdata;

    always_comb
    begin
        if (cmd.write_en)
        begin
            sel_x = vx_reg;
            sel_z = vz_reg;
        end
        else
        begin
            sel_x = cell_x_reg + SIZE_W'(cmd.vtx[0]);
            sel_z = cell_z_reg + SIZE_W'(cmd.vtx[1]);
        end
        vtx_addr  = AW'(sel_z) * ROW_STEP + AW'(sel_x);
        ram_addr  = cmd.clear_en ? clr_addr_reg : vtx_addr;
        ram_en    = cmd.clear_en || cmd.write_en || cmd.rd_en;
        ram_we    = cmd.clear_en || (cmd.write_en && !err_reg);
        ram_wdata = cmd.clear_en ? '0 : value_reg;
    end

    hbs_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Weight of the vertex being read, lined up with its registered read data
    logic [SIZE_W-1:0]   wx, wz;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [BLEND_W-1:0]  prod_reg, acc_reg;
    logic [SCALED_W-1:0] scaled_reg;

    always_comb
    begin
        wx = cmd.vtx[0] ? frac_x_reg : (9'd256 - frac_x_reg);
        wz = cmd.vtx[1] ? frac_z_reg : (9'd256 - frac_z_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            weight_reg <= WEIGHT_W'({9'd0, wx} * {9'd0, wz});
        end
        if (cmd.mul_en)
        begin
            prod_reg <= BLEND_W'(ram_rdata) * BLEND_W'(weight_reg);
        end
        if (cmd.capture)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.scale_en)
        begin
            scaled_reg <= SCALED_W'(acc_reg) * SCALED_W'(maxh_eff);
        end
    end

    // Divide by 65535 with round half up: m = a*65536 + b = a*65535 + (a + b)
    logic [SCALED_W-1:0] biased;
    logic [27:0]         fold_a_reg;
    logic [28:0]         fold_s_reg;

    assign biased = scaled_reg + ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (cmd.reduce_en)
        begin
            fold_a_reg <= biased[SCALED_W-1:16];
            fold_s_reg <= 29'(biased[SCALED_W-1:16]) + 29'(biased[15:0]);
        end
    end

    logic [12:0]        fold_a2;
    logic [16:0]        fold_r;
    logic [WORLD_W-1:0] quotient;

    always_comb
    begin
        fold_a2  = fold_s_reg[28:16];
        fold_r   = 17'(fold_a2) + 17'(fold_s_reg[15:0]);
        quotient = WORLD_W'(fold_a_reg) + WORLD_W'(fold_a2)
                 + WORLD_W'(fold_r >= FULL_SCALE);
    end

    // Result word
    logic               done_reg;
    logic [WORLD_W-1:0] world_height_reg;
    logic               status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.load_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            world_height_reg <= ((kind_reg == KIND_SAMPLE) && !err_reg) ? quotient : '0;
            status_reg       <= err_reg;
        end
    end

    assign done         = done_reg;
    assign world_height = world_height_reg;
    assign status       = status_reg;

endmodule

// ----- src/heightmap_bilinear_sampler.sv -----
// Top level of the heightmap bilinear sampler.
//
// Holds a (GRID_SIZE+1) x (GRID_SIZE+1) grid of 16-bit vertex heights in one
// single-port RAM and answers one command word at a time. A command is taken
// on a rising edge with start high and busy low; kind selects a vertex write
// or a bilinear sample at (sample_x, sample_z), 8 fraction bits each. Every
// command gives exactly one result word, shown on world_height and status for
// a single cycle marked by done; there is no back-pressure, so capture the
// word in that cycle. world_height carries 16 fraction bits and is zero for
// writes and for rejected coordinates; status is 1 when a sample point or a
// written vertex lies outside the active terrain_size grid. Steps: a sample
// runs four back-to-back vertex reads on the one RAM port, drains the weight
// multiply and accumulate, then scale, fold and result load; a write runs the
// RAM write then the result load, and a rejected sample goes straight to the
// result load. done is registered from the result load and so comes in the
// cycle after it, where busy has dropped again. After reset busy stays high
// while a sweep zeroes the grid one entry a cycle; configuration writes
// through cfg_wr_en, cfg_index and cfg_data land at once, also during the
// sweep, and must only be issued while no command is in flight.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  logic [COORD_W-1:0]    sample_x,
    input  logic [COORD_W-1:0]    sample_z,
    input  logic [SIZE_W-1:0]     vertex_x,
    input  logic [SIZE_W-1:0]     vertex_z,
    input  logic [HEIGHT_W-1:0]   vertex_value,
    output logic                  done,
    output logic [WORLD_W-1:0]    world_height,
    output logic                  status
);

    hbs_cmd_t  cmd;
    hbs_stat_t stat;

    // Sequence the clear sweep, the write, the four-vertex fetch, scale, fold and result load.
    hbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold config, grid RAM, weight multiply, accumulate, scale, fold and result word.
    hbs_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .sample_x     (sample_x),
        .sample_z     (sample_z),
        .vertex_x     (vertex_x),
        .vertex_z     (vertex_z),
        .vertex_value (vertex_value),
        .cmd          (cmd),
        .stat         (stat),
        .done         (done),
        .world_height (world_height),
        .status       (status)
    );

endmodule
